// ----- hw/rtl/god_pkg.sv -----
// Shared types, constants and dither threshold tables for the gamma ordered dither.
// No dependencies; compile first.
package god_pkg;

  localparam int unsigned PIX_W           = 8;
  localparam int unsigned GREY_LEVELS     = 256;
  localparam int unsigned MAX_DIM_DEFAULT = 4096;
  localparam int unsigned CFG_DIM_W       = 13;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned THR_W           = 9;
  localparam logic [PIX_W-1:0] PIX_WHITE  = 8'hFF;
  localparam logic [PIX_W-1:0] PIX_BLACK  = 8'h00;

  localparam logic [CFG_DIM_W-1:0] WIDTH_RESET  = 13'd512;
  localparam logic [CFG_DIM_W-1:0] HEIGHT_RESET = 13'd512;

  typedef enum logic {
    OP_DITHER = 1'b0,
    OP_LOAD   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    MSIZE_2X2 = 2'd0,
    MSIZE_3X3 = 2'd1,
    MSIZE_4X4 = 2'd2,
    MSIZE_8X8 = 2'd3
  } msize_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_MSIZE  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    op_e              operation;
    logic [PIX_W-1:0] pixel_in;
    logic [PIX_W-1:0] table_index;
    logic [PIX_W-1:0] table_value;
  } in_beat_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             frame_end;
  } out_beat_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DIM_W-1:0] data;
  } cfg_beat_t;

  // Bayer matrices, flattened as [column][row]
  localparam logic [5:0] DM2 [4] = '{6'd0, 6'd2, 6'd3, 6'd1};
  // 3x3 padded to a 4x4 grid; the unused slots are never addressed
  localparam logic [5:0] DM3 [16] = '{
    6'd6, 6'd8, 6'd4, 6'd0,
    6'd1, 6'd0, 6'd3, 6'd0,
    6'd5, 6'd2, 6'd7, 6'd0,
    6'd0, 6'd0, 6'd0, 6'd0};
  localparam logic [5:0] DM4 [16] = '{
    6'd0,  6'd8,  6'd2,  6'd10,
    6'd12, 6'd4,  6'd14, 6'd6,
    6'd3,  6'd11, 6'd1,  6'd9,
    6'd15, 6'd7,  6'd13, 6'd5};
  localparam logic [5:0] DM8 [64] = '{
    6'd0,  6'd32, 6'd8,  6'd40, 6'd2,  6'd34, 6'd10, 6'd42,
    6'd48, 6'd16, 6'd56, 6'd24, 6'd50, 6'd18, 6'd58, 6'd26,
    6'd12, 6'd44, 6'd4,  6'd36, 6'd14, 6'd46, 6'd6,  6'd38,
    6'd60, 6'd28, 6'd52, 6'd20, 6'd62, 6'd30, 6'd54, 6'd22,
    6'd3,  6'd35, 6'd11, 6'd43, 6'd1,  6'd33, 6'd9,  6'd41,
    6'd51, 6'd19, 6'd59, 6'd27, 6'd49, 6'd17, 6'd57, 6'd25,
    6'd15, 6'd47, 6'd7,  6'd39, 6'd13, 6'd45, 6'd5,  6'd37,
    6'd63, 6'd31, 6'd55, 6'd23, 6'd61, 6'd29, 6'd53, 6'd21};

  // Quantizer step per matrix order: GREY_LEVELS / (m*m)
  function automatic logic [6:0] quant_step(msize_e sel);
    logic [6:0] step;
    unique case (sel)
      MSIZE_2X2: step = 7'(GREY_LEVELS / 4);
      MSIZE_3X3: step = 7'(GREY_LEVELS / 9);
      MSIZE_4X4: step = 7'(GREY_LEVELS / 16);
      MSIZE_8X8: step = 7'(GREY_LEVELS / 64);
      default:   step = 7'(GREY_LEVELS / 16);
    endcase
    return step;
  endfunction

  // level > D  <=>  value >= step * (D + 1), so return that bound.
  // c and r are already reduced modulo the matrix order.
  function automatic logic [THR_W-1:0] dither_bound(msize_e sel, logic [2:0] c,
                                                    logic [2:0] r);
    logic [5:0]  d;
    logic [13:0] prod;
    unique case (sel)
      MSIZE_2X2: d = DM2[{c[0], r[0]}];
      MSIZE_3X3: d = DM3[{c[1:0], r[1:0]}];
      MSIZE_4X4: d = DM4[{c[1:0], r[1:0]}];
      MSIZE_8X8: d = DM8[{c, r}];
      default:   d = DM4[{c[1:0], r[1:0]}];
    endcase
    prod = 14'(quant_step(sel)) * (14'(d) + 14'd1);
    return prod[THR_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/god_stream_if.sv -----
// Valid/ready channel carrying one payload beat per handshake.
// Payload type is a parameter; no other dependencies.
interface god_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/god_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module god_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/gamma_ordered_dither.sv -----
// Gamma-corrected ordered dither for a raster grey pixel stream.
// Depends on god_pkg, god_stream_if and god_ram.
//
// Channels: stream_i takes in_beat_t beats. A load beat (operation OP_LOAD)
// writes table_value into gamma table entry table_index and gives no result.
// A dither beat maps pixel_in through the table, compares the quantized level
// with the Bayer matrix entry at (column mod m, row mod m) and gives one
// out_beat_t on result_o: 0 or 255, with frame_end on the last pixel.
// cfg_i writes image_width (index 0), image_height (1) and matrix_size (2);
// it is always ready; the user must write it only while the stream is idle, as the block does not enforce this.
//
// Throughput: one beat per cycle while result_o.ready is high. A dither
// result is held in the gamma table read register, then in the output register.
// Reset: 512 x 512 frame, 4x4 matrix, raster position at zero. The gamma
// table has no reset; load every entry that pixels will use first.
// Stall: the output register holds its beat while result_o.ready is low, and
// the table read stage still accepts one more pixel before stream_i.ready drops.
module gamma_ordered_dither import god_pkg::*; #(
  parameter int unsigned MAX_DIM = MAX_DIM_DEFAULT
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  god_stream_if.sink   stream_i,
  god_stream_if.source result_o,
  god_stream_if.sink   cfg_i
);

  localparam int unsigned CntW = $clog2(MAX_DIM);
  localparam int unsigned CmpW = (CFG_DIM_W > CntW + 1) ? CFG_DIM_W : CntW + 1;
  localparam int unsigned Digits = (CntW + 1) / 2;

  // Modulo 3 of a counter: base-4 digits sum to the same residue
  function automatic logic [1:0] mod3(logic [CntW-1:0] v);
    logic [2*Digits-1:0] p;
    logic [7:0]          s;
    p = (2*Digits)'(v);
    s = '0;
    for (int i = 0; i < Digits; i++) begin
      s = s + 8'(p[2*i +: 2]);
    end
    for (int k = 0; k < 4; k++) begin
      s = 8'(s[7:2]) + 8'(s[1:0]);
    end
    return (s[1:0] == 2'd3) ? 2'd0 : s[1:0];
  endfunction

  // Clamp a frame dimension to 1..MAX_DIM and return it minus one
  function automatic logic [CmpW-1:0] last_index(logic [CFG_DIM_W-1:0] dim);
    logic [CmpW-1:0] ext;
    ext = CmpW'(dim);
    if (ext == '0) begin
      ext = CmpW'(1);
    end else if (ext > CmpW'(MAX_DIM)) begin
      ext = CmpW'(MAX_DIM);
    end
    return ext - CmpW'(1);
  endfunction

  // Configuration registers
  logic [CFG_DIM_W-1:0] width_q, height_q;
  msize_e               msize_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
      msize_q  <= MSIZE_4X4;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.payload.index))
        CFG_WIDTH:  width_q  <= cfg_i.payload.data;
        CFG_HEIGHT: height_q <= cfg_i.payload.data;
        CFG_MSIZE:  msize_q  <= msize_e'(cfg_i.payload.data[1:0]);
        default: ;
      endcase
    end
  end

  // Handshake control
  logic in_fire, pix_fire, load_fire;
  logic s1_valid_q, s1_advance;
  logic out_valid_q;

  assign s1_advance     = s1_valid_q && (!out_valid_q || result_o.ready);
  assign stream_i.ready = !s1_valid_q || s1_advance;
  assign in_fire        = stream_i.valid && stream_i.ready;
  assign pix_fire       = in_fire && (stream_i.payload.operation == OP_DITHER);
  assign load_fire      = in_fire && (stream_i.payload.operation == OP_LOAD);

  // Raster position and threshold lookup
  logic [CntW-1:0]  col_q, row_q, col_d, row_d;
  logic [2:0]       col_mod, row_mod;
  logic             row_end, frame_end_d;
  logic [THR_W-1:0] bound_d;

  always_comb begin
    unique case (msize_q)
      MSIZE_2X2: begin
        col_mod = {2'b0, col_q[0]};
        row_mod = {2'b0, row_q[0]};
      end
      MSIZE_3X3: begin
        col_mod = {1'b0, mod3(col_q)};
        row_mod = {1'b0, mod3(row_q)};
      end
      MSIZE_4X4: begin
        col_mod = {1'b0, col_q[1:0]};
        row_mod = {1'b0, row_q[1:0]};
      end
      MSIZE_8X8: begin
        col_mod = col_q[2:0];
        row_mod = row_q[2:0];
      end
      default: begin
        col_mod = 3'd0;
        row_mod = 3'd0;
      end
    endcase
  end

  assign bound_d     = dither_bound(msize_q, col_mod, row_mod);
  assign row_end     = CmpW'(col_q) >= last_index(width_q);
  assign frame_end_d = row_end && (CmpW'(row_q) >= last_index(height_q));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (row_end) begin
      col_d = '0;
      row_d = frame_end_d ? '0 : row_q + CntW'(1);
    end else begin
      col_d = col_q + CntW'(1);
    end
  end

  // Advance the position on every dither beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (pix_fire) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Gamma table
  logic [PIX_W-1:0] gamma_rdata;

  god_ram #(
    .WIDTH (PIX_W),
    .DEPTH (GREY_LEVELS)
  ) u_gamma_ram (
    .clk_i   (clk_i),
    .we_i    (load_fire),
    .waddr_i (stream_i.payload.table_index),
    .wdata_i (stream_i.payload.table_value),
    .re_i    (pix_fire),
    .raddr_i (stream_i.payload.pixel_in),
    .rdata_o (gamma_rdata)
  );

  // Table read stage: bound and frame flag travel with the read
  logic [THR_W-1:0] bound_q;
  logic             s1_frame_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (pix_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_fire) begin
      bound_q        <= bound_d;
      s1_frame_end_q <= frame_end_d;
    end
  end

  // Output register: compare and hold while stalled
  out_beat_t out_q, out_d;

  assign out_d.pixel_out = ({1'b0, gamma_rdata} >= bound_q) ? PIX_WHITE : PIX_BLACK;
  assign out_d.frame_end = s1_frame_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_advance) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      out_q <= out_d;
    end
  end

  assign result_o.valid   = out_valid_q;
  assign result_o.payload = out_q;

  // Checks
  a_pix_enters_read_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_fire |=> s1_valid_q)
    else $error("accepted pixel did not enter the table read stage");

  a_load_keeps_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_fire |=> $stable(col_q) && $stable(row_q))
    else $error("load beat moved the raster position");

  a_frame_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_fire && frame_end_d |=> (col_q == '0) && (row_q == '0))
    else $error("raster position did not wrap after the last pixel of a frame");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stream_i.ready |-> s1_valid_q && out_valid_q && !result_o.ready)
    else $error("input stalled with room in the pipeline");

  a_binary_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (result_o.payload.pixel_out == PIX_WHITE) ||
                       (result_o.payload.pixel_out == PIX_BLACK))
    else $error("dithered pixel is neither black nor white");

endmodule
